### rtl/core/prqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prqs_pkg;

    // Fixed field widths of the item ports
    localparam int OP_W   = 2;
    localparam int ID_W   = 5;
    localparam int PRIO_W = 5;

    // Widest thread or level index over the supported parameter range
    localparam int IDX_W = 8;

    localparam int LEVELS_DEF  = 32;
    localparam int THREADS_DEF = 32;

    // Update of the queue store for one item; addresses and data are
    // zero-extended to IDX_W and cut to the real index width in the store.
    typedef struct packed {
        logic             next_en;
        logic [IDX_W-1:0] next_addr;
        logic [IDX_W-1:0] next_data;
        logic             prev_en;
        logic [IDX_W-1:0] prev_addr;
        logic [IDX_W-1:0] prev_data;
        logic             head_a_en;
        logic [IDX_W-1:0] head_a_addr;
        logic [IDX_W-1:0] head_a_data;
        logic             head_b_en;
        logic [IDX_W-1:0] head_b_addr;
        logic [IDX_W-1:0] head_b_data;
        logic             tail_en;
        logic [IDX_W-1:0] tail_addr;
        logic [IDX_W-1:0] tail_data;
        logic             ne_set_en;
        logic [IDX_W-1:0] ne_set_addr;
        logic             ne_clr_en;
        logic [IDX_W-1:0] ne_clr_addr;
        logic             q_set_en;
        logic [IDX_W-1:0] q_set_addr;
        logic             q_clr_en;
        logic [IDX_W-1:0] q_clr_addr;
        logic             lvl_en;
        logic [IDX_W-1:0] lvl_addr;
        logic [IDX_W-1:0] lvl_data;
    } t_store_wr;

endpackage

`default_nettype wire

### rtl/core/prqs_best_level.sv
`timescale 1ns / 1ps
`default_nettype none

module prqs_best_level
    import prqs_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  wire logic [LEVELS-1:0]         i_nonempty,
    output logic                           o_found,
    output logic [$clog2(LEVELS)-1:0]      o_level
);

    localparam int LW = $clog2(LEVELS);

    // Highest set bit wins
    always_comb begin
        o_level = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (i_nonempty[l]) begin
                o_level = LW'(l);
            end
        end
    end

    assign o_found = |i_nonempty;

endmodule

`default_nettype wire

### rtl/core/prqs_queue_store.sv
`timescale 1ns / 1ps
`default_nettype none

module prqs_queue_store
    import prqs_pkg::*;
#(
    parameter int LEVELS  = LEVELS_DEF,
    parameter int THREADS = THREADS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire t_store_wr                   i_wr,
    output logic [$clog2(THREADS)-1:0]       o_head     [LEVELS],
    output logic [$clog2(THREADS)-1:0]       o_tail     [LEVELS],
    output logic [LEVELS-1:0]                o_nonempty,
    output logic [$clog2(THREADS)-1:0]       o_next     [THREADS],
    output logic [$clog2(THREADS)-1:0]       o_prev     [THREADS],
    output logic [THREADS-1:0]               o_queued,
    output logic [$clog2(LEVELS)-1:0]        o_level    [THREADS]
);

    localparam int LW = $clog2(LEVELS);
    localparam int TW = $clog2(THREADS);

    logic [TW-1:0]      r_head     [LEVELS];
    logic [TW-1:0]      r_tail     [LEVELS];
    logic [LEVELS-1:0]  r_nonempty;
    logic [TW-1:0]      r_next     [THREADS];
    logic [TW-1:0]      r_prev     [THREADS];
    logic [THREADS-1:0] r_queued;
    logic [LW-1:0]      r_level    [THREADS];

    // Link and pointer storage: only read after being written
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_wr.next_en) begin
                r_next[i_wr.next_addr[TW-1:0]] <= i_wr.next_data[TW-1:0];
            end
            if (i_wr.prev_en) begin
                r_prev[i_wr.prev_addr[TW-1:0]] <= i_wr.prev_data[TW-1:0];
            end
            if (i_wr.head_a_en) begin
                r_head[i_wr.head_a_addr[LW-1:0]] <= i_wr.head_a_data[TW-1:0];
            end
            if (i_wr.head_b_en) begin
                r_head[i_wr.head_b_addr[LW-1:0]] <= i_wr.head_b_data[TW-1:0];
            end
            if (i_wr.tail_en) begin
                r_tail[i_wr.tail_addr[LW-1:0]] <= i_wr.tail_data[TW-1:0];
            end
            if (i_wr.lvl_en) begin
                r_level[i_wr.lvl_addr[TW-1:0]] <= i_wr.lvl_data[LW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
            r_queued   <= '0;
        end else if (i_en) begin
            if (i_wr.ne_clr_en) begin
                r_nonempty[i_wr.ne_clr_addr[LW-1:0]] <= 1'b0;
            end
            if (i_wr.ne_set_en) begin
                r_nonempty[i_wr.ne_set_addr[LW-1:0]] <= 1'b1;
            end
            if (i_wr.q_clr_en) begin
                r_queued[i_wr.q_clr_addr[TW-1:0]] <= 1'b0;
            end
            if (i_wr.q_set_en) begin
                r_queued[i_wr.q_set_addr[TW-1:0]] <= 1'b1;
            end
        end
    end

    assign o_head     = r_head;
    assign o_tail     = r_tail;
    assign o_nonempty = r_nonempty;
    assign o_next     = r_next;
    assign o_prev     = r_prev;
    assign o_queued   = r_queued;
    assign o_level    = r_level;

endmodule

`default_nettype wire

### rtl/core/priority_ready_queue_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Fixed-priority scheduler with one FIFO ready queue per level (higher level is
// more urgent) and one running thread. Each item is add, remove or next and
// yields exactly one result with the running thread after it. An accepted item
// is executed against the linked-list registers while it sits in the input
// register and the result register is free or being drained, and it lands in the
// result register at that edge. One item per cycle is sustained while the result
// side does not stall, because every queue update (link, unlink, requeue plus pop)
// is done in the execute step. Queue state needs no clearing pass after reset.
module priority_ready_queue_scheduler_top
    import prqs_pkg::*;
#(
    parameter int LEVELS  = LEVELS_DEF,
    parameter int THREADS = THREADS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [ID_W-1:0]   i_thread_id,
    input  wire logic [PRIO_W-1:0] i_thread_priority,
    input  wire logic              i_current_runnable,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [ID_W-1:0]        o_running_id,
    output logic                   o_running_valid,
    output logic                   o_switched,
    output logic                   o_reschedule_request,
    output logic                   o_bad_request
);

    localparam int LW = $clog2(LEVELS);
    localparam int TW = $clog2(THREADS);

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_NEXT   = 2'd2
    } t_op;

    // Input register
    logic              r_in_vld;
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_pr;
    logic              r_rn;

    // Running thread
    logic [TW-1:0] r_run;
    logic          r_present;
    logic          r_dead;
    logic [TW-1:0] n_run;
    logic          n_present;
    logic          n_dead;
    logic          n_resched;
    logic          n_bad;

    // Result register
    logic            r_out_vld;
    logic [ID_W-1:0] r_o_id;
    logic            r_o_valid;
    logic            r_o_switched;
    logic            r_o_resched;
    logic            r_o_bad;

    logic      exec;
    t_store_wr n_wr;

    logic [TW-1:0]      w_head     [LEVELS];
    logic [TW-1:0]      w_tail     [LEVELS];
    logic [LEVELS-1:0]  w_nonempty;
    logic [TW-1:0]      w_next     [THREADS];
    logic [TW-1:0]      w_prev     [THREADS];
    logic [THREADS-1:0] w_queued;
    logic [LW-1:0]      w_level    [THREADS];
    logic               w_found;
    logic [LW-1:0]      w_best;

    logic          id_ok;
    logic [TW-1:0] id_t;
    logic [LW-1:0] lv_add;
    logic          is_running;
    logic [TW-1:0] add_tail;
    logic [LW-1:0] id_lv;
    logic [TW-1:0] id_next;
    logic [TW-1:0] id_prev;
    logic          rm_is_head;
    logic          rm_is_tail;
    logic [LW-1:0] run_lv;
    logic [TW-1:0] run_tail;
    logic [TW-1:0] nx;
    logic [TW-1:0] nx_next;
    logic [TW-1:0] b_tail;
    logic          b_single;
    logic          keep;

    assign exec       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op <= i_operation;
            r_id <= i_thread_id;
            r_pr <= i_thread_priority;
            r_rn <= i_current_runnable;
        end
    end

    prqs_queue_store #(
        .LEVELS  (LEVELS),
        .THREADS (THREADS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (exec),
        .i_wr       (n_wr),
        .o_head     (w_head),
        .o_tail     (w_tail),
        .o_nonempty (w_nonempty),
        .o_next     (w_next),
        .o_prev     (w_prev),
        .o_queued   (w_queued),
        .o_level    (w_level)
    );

    prqs_best_level #(
        .LEVELS (LEVELS)
    ) u_best (
        .i_nonempty (w_nonempty),
        .o_found    (w_found),
        .o_level    (w_best)
    );

    // Operand fetch
    assign id_ok      = int'(r_id) < THREADS;
    assign id_t       = TW'(r_id);
    assign lv_add     = (int'(r_pr) >= LEVELS) ? LW'(LEVELS - 1) : LW'(r_pr);
    assign is_running = id_ok && r_present && (r_run == id_t);
    assign add_tail   = w_tail[lv_add];
    assign id_lv      = w_level[id_t];
    assign id_next    = w_next[id_t];
    assign id_prev    = w_prev[id_t];
    assign rm_is_head = w_head[id_lv] == id_t;
    assign rm_is_tail = w_tail[id_lv] == id_t;
    assign run_lv     = w_level[r_run];
    assign run_tail   = w_tail[run_lv];
    assign nx         = w_head[w_best];
    assign nx_next    = w_next[nx];
    assign b_tail     = w_tail[w_best];
    assign b_single   = b_tail == nx;
    assign keep       = r_present && r_rn && !r_dead;

    always_comb begin
        n_wr      = '0;
        n_run     = r_run;
        n_present = r_present;
        n_dead    = r_dead;
        n_resched = 1'b0;
        n_bad     = 1'b0;
        case (t_op'(r_op))
            OP_ADD: begin
                if (!id_ok || w_queued[id_t] || is_running) begin
                    n_bad = 1'b1;
                end else begin
                    n_wr.lvl_en   = 1'b1;
                    n_wr.lvl_addr = IDX_W'(id_t);
                    n_wr.lvl_data = IDX_W'(lv_add);
                    if (!r_present) begin
                        n_run     = id_t;
                        n_present = 1'b1;
                        n_dead    = 1'b0;
                    end else begin
                        n_wr.tail_en    = 1'b1;
                        n_wr.tail_addr  = IDX_W'(lv_add);
                        n_wr.tail_data  = IDX_W'(id_t);
                        n_wr.q_set_en   = 1'b1;
                        n_wr.q_set_addr = IDX_W'(id_t);
                        if (w_nonempty[lv_add]) begin
                            n_wr.next_en   = 1'b1;
                            n_wr.next_addr = IDX_W'(add_tail);
                            n_wr.next_data = IDX_W'(id_t);
                            n_wr.prev_en   = 1'b1;
                            n_wr.prev_addr = IDX_W'(id_t);
                            n_wr.prev_data = IDX_W'(add_tail);
                        end else begin
                            n_wr.head_a_en   = 1'b1;
                            n_wr.head_a_addr = IDX_W'(lv_add);
                            n_wr.head_a_data = IDX_W'(id_t);
                            n_wr.ne_set_en   = 1'b1;
                            n_wr.ne_set_addr = IDX_W'(lv_add);
                        end
                    end
                end
            end
            OP_REMOVE: begin
                if (!id_ok) begin
                    n_bad = 1'b1;
                end else if (is_running) begin
                    n_dead    = 1'b1;
                    n_resched = 1'b1;
                end else if (w_queued[id_t]) begin
                    n_wr.q_clr_en   = 1'b1;
                    n_wr.q_clr_addr = IDX_W'(id_t);
                    if (rm_is_head && rm_is_tail) begin
                        n_wr.ne_clr_en   = 1'b1;
                        n_wr.ne_clr_addr = IDX_W'(id_lv);
                    end else if (rm_is_head) begin
                        n_wr.head_a_en   = 1'b1;
                        n_wr.head_a_addr = IDX_W'(id_lv);
                        n_wr.head_a_data = IDX_W'(id_next);
                    end else if (rm_is_tail) begin
                        n_wr.tail_en   = 1'b1;
                        n_wr.tail_addr = IDX_W'(id_lv);
                        n_wr.tail_data = IDX_W'(id_prev);
                    end else begin
                        n_wr.next_en   = 1'b1;
                        n_wr.next_addr = IDX_W'(id_prev);
                        n_wr.next_data = IDX_W'(id_next);
                        n_wr.prev_en   = 1'b1;
                        n_wr.prev_addr = IDX_W'(id_next);
                        n_wr.prev_data = IDX_W'(id_prev);
                    end
                end else begin
                    n_bad = 1'b1;
                end
            end
            OP_NEXT: begin
                if (!keep) begin
                    // Drop the running thread, then start the best ready one
                    n_run     = '0;
                    n_present = 1'b0;
                    n_dead    = 1'b0;
                    if (w_found) begin
                        n_run           = nx;
                        n_present       = 1'b1;
                        n_wr.q_clr_en   = 1'b1;
                        n_wr.q_clr_addr = IDX_W'(nx);
                        if (b_single) begin
                            n_wr.ne_clr_en   = 1'b1;
                            n_wr.ne_clr_addr = IDX_W'(w_best);
                        end else begin
                            n_wr.head_a_en   = 1'b1;
                            n_wr.head_a_addr = IDX_W'(w_best);
                            n_wr.head_a_data = IDX_W'(nx_next);
                        end
                    end
                end else if (w_found && (run_lv <= w_best)) begin
                    // Requeue the running thread at the back, then pop the best head.
                    // A thread that outranks every ready one simply keeps running.
                    n_run           = nx;
                    n_wr.q_set_en   = 1'b1;
                    n_wr.q_set_addr = IDX_W'(r_run);
                    n_wr.q_clr_en   = 1'b1;
                    n_wr.q_clr_addr = IDX_W'(nx);
                    n_wr.tail_en    = 1'b1;
                    n_wr.tail_addr  = IDX_W'(run_lv);
                    n_wr.tail_data  = IDX_W'(r_run);
                    if (run_lv == w_best) begin
                        n_wr.next_en     = 1'b1;
                        n_wr.next_addr   = IDX_W'(b_tail);
                        n_wr.next_data   = IDX_W'(r_run);
                        n_wr.prev_en     = 1'b1;
                        n_wr.prev_addr   = IDX_W'(r_run);
                        n_wr.prev_data   = IDX_W'(b_tail);
                        n_wr.head_a_en   = 1'b1;
                        n_wr.head_a_addr = IDX_W'(w_best);
                        n_wr.head_a_data = b_single ? IDX_W'(r_run) : IDX_W'(nx_next);
                    end else begin
                        if (w_nonempty[run_lv]) begin
                            n_wr.next_en   = 1'b1;
                            n_wr.next_addr = IDX_W'(run_tail);
                            n_wr.next_data = IDX_W'(r_run);
                            n_wr.prev_en   = 1'b1;
                            n_wr.prev_addr = IDX_W'(r_run);
                            n_wr.prev_data = IDX_W'(run_tail);
                        end else begin
                            n_wr.head_b_en   = 1'b1;
                            n_wr.head_b_addr = IDX_W'(run_lv);
                            n_wr.head_b_data = IDX_W'(r_run);
                            n_wr.ne_set_en   = 1'b1;
                            n_wr.ne_set_addr = IDX_W'(run_lv);
                        end
                        if (b_single) begin
                            n_wr.ne_clr_en   = 1'b1;
                            n_wr.ne_clr_addr = IDX_W'(w_best);
                        end else begin
                            n_wr.head_a_en   = 1'b1;
                            n_wr.head_a_addr = IDX_W'(w_best);
                            n_wr.head_a_data = IDX_W'(nx_next);
                        end
                    end
                end
            end
            default: begin
                // Unused code: report status only
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= '0;
            r_present <= 1'b0;
            r_dead    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (exec) begin
                r_run     <= n_run;
                r_present <= n_present;
                r_dead    <= n_dead;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_o_id       <= ID_W'(n_run);
            r_o_valid    <= n_present;
            r_o_switched <= (n_present != r_present) || (n_present && (n_run != r_run));
            r_o_resched  <= n_resched;
            r_o_bad      <= n_bad;
        end
    end

    assign o_out_valid          = r_out_vld;
    assign o_running_id         = r_o_id;
    assign o_running_valid      = r_o_valid;
    assign o_switched           = r_o_switched;
    assign o_reschedule_request = r_o_resched;
    assign o_bad_request        = r_o_bad;

endmodule

`default_nettype wire

### dv/prqs_checker.sv
`timescale 1ns / 1ps

package prqs_tb_pkg;
    import prqs_pkg::*;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_NEXT   = 2'd2,
        OP_SPARE  = 2'd3
    } sched_op_e;

    typedef struct packed {
        logic [ID_W-1:0] running_id;
        logic            running_valid;
        logic            switched;
        logic            reschedule_request;
        logic            bad_request;
    } sched_result_t;
endpackage

module prqs_checker
    import prqs_pkg::*;
    import prqs_tb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [ID_W-1:0]   i_thread_id,
    input  wire logic [PRIO_W-1:0] i_thread_priority,
    input  wire logic              i_current_runnable,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic [ID_W-1:0]   i_running_id,
    input  wire logic              i_running_valid,
    input  wire logic              i_switched,
    input  wire logic              i_reschedule_request,
    input  wire logic              i_bad_request,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int NLEV = LEVELS_DEF;
    localparam int NTHR = THREADS_DEF;

    logic [ID_W-1:0]   lvl_head [NLEV];
    logic [ID_W-1:0]   lvl_tail [NLEV];
    logic              lvl_busy [NLEV];
    logic [ID_W-1:0]   nxt [NTHR];
    logic [ID_W-1:0]   prv [NTHR];
    logic              in_queue [NTHR];
    logic [PRIO_W-1:0] thr_level [NTHR];
    logic [ID_W-1:0]   cur_id;
    logic              cur_present;
    logic              cur_dead;

    sched_result_t sched_expect_q[$];
    int fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic int top_level();
        for (int lv = NLEV - 1; lv >= 0; lv--) begin
            if (lvl_busy[lv]) return lv;
        end
        return -1;
    endfunction

    function automatic void enqueue(logic [ID_W-1:0] t, bit at_front);
        logic [PRIO_W-1:0] lv;
        lv = thr_level[t];
        if (!lvl_busy[lv]) begin
            lvl_head[lv] = t;
            lvl_tail[lv] = t;
            lvl_busy[lv] = 1'b1;
        end else if (at_front) begin
            prv[lvl_head[lv]] = t;
            nxt[t] = lvl_head[lv];
            lvl_head[lv] = t;
        end else begin
            nxt[lvl_tail[lv]] = t;
            prv[t] = lvl_tail[lv];
            lvl_tail[lv] = t;
        end
        in_queue[t] = 1'b1;
    endfunction

    function automatic void dequeue(logic [ID_W-1:0] t);
        logic [PRIO_W-1:0] lv;
        lv = thr_level[t];
        if (lvl_head[lv] == t && lvl_tail[lv] == t) begin
            lvl_busy[lv] = 1'b0;
        end else if (lvl_head[lv] == t) begin
            lvl_head[lv] = nxt[t];
        end else if (lvl_tail[lv] == t) begin
            lvl_tail[lv] = prv[t];
        end else begin
            nxt[prv[t]] = nxt[t];
            prv[nxt[t]] = prv[t];
        end
        in_queue[t] = 1'b0;
    endfunction

    function automatic sched_result_t schedule(sched_op_e op, logic [ID_W-1:0] id,
                                               logic [PRIO_W-1:0] prio, logic run);
        sched_result_t r;
        logic [ID_W-1:0] old_id;
        logic old_present;
        int best;
        bit keep;
        r = '0;
        old_id = cur_id;
        old_present = cur_present;
        case (op)
            OP_ADD: begin
                if (in_queue[id] || (cur_present && cur_id == id)) begin
                    r.bad_request = 1'b1;
                end else begin
                    thr_level[id] = prio;
                    if (!cur_present) begin
                        cur_id = id;
                        cur_present = 1'b1;
                        cur_dead = 1'b0;
                    end else begin
                        enqueue(id, 1'b0);
                    end
                end
            end
            OP_REMOVE: begin
                if (cur_present && cur_id == id) begin
                    cur_dead = 1'b1;
                    r.reschedule_request = 1'b1;
                end else if (in_queue[id]) begin
                    dequeue(id);
                end else begin
                    r.bad_request = 1'b1;
                end
            end
            OP_NEXT: begin
                best = top_level();
                keep = cur_present && run && !cur_dead;
                if (keep) begin
                    // a thread that outranks every ready one goes back to the front
                    if (best >= 0) enqueue(cur_id, int'(thr_level[cur_id]) > best);
                end else begin
                    cur_present = 1'b0;
                    cur_dead = 1'b0;
                    cur_id = '0;
                end
                best = top_level();
                if (best >= 0) begin
                    cur_id = lvl_head[best];
                    dequeue(cur_id);
                    cur_present = 1'b1;
                    cur_dead = 1'b0;
                end
            end
            default: ;
        endcase
        r.running_id = cur_id;
        r.running_valid = cur_present;
        r.switched = (cur_present != old_present) || (cur_present && cur_id != old_id);
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        sched_result_t want;
        if (!i_rst_n) begin
            foreach (lvl_busy[i]) begin
                lvl_busy[i] = 1'b0;
                lvl_head[i] = '0;
                lvl_tail[i] = '0;
            end
            foreach (in_queue[i]) begin
                in_queue[i] = 1'b0;
                nxt[i] = '0;
                prv[i] = '0;
                thr_level[i] = '0;
            end
            cur_id = '0;
            cur_present = 1'b0;
            cur_dead = 1'b0;
            sched_expect_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (sched_expect_q.size() == 0) begin
                    $error("result with no item outstanding: running_id %0d", i_running_id);
                    fails++;
                end else begin
                    want = sched_expect_q.pop_front();
                    check_field("running_id", int'(want.running_id), int'(i_running_id));
                    check_field("running_valid", int'(want.running_valid),
                                int'(i_running_valid));
                    check_field("switched", int'(want.switched), int'(i_switched));
                    check_field("reschedule_request", int'(want.reschedule_request),
                                int'(i_reschedule_request));
                    check_field("bad_request", int'(want.bad_request), int'(i_bad_request));
                end
            end
            if (i_in_valid && i_in_ready) begin
                sched_expect_q.push_back(schedule(sched_op_e'(i_operation), i_thread_id,
                                                  i_thread_priority, i_current_runnable));
            end
        end
        o_pending <= sched_expect_q.size();
        o_fail_count <= fails;
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import prqs_pkg::*;
    import prqs_tb_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   operation = '0;
    logic [ID_W-1:0]   thread_id = '0;
    logic [PRIO_W-1:0] thread_priority = '0;
    logic              current_runnable = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ID_W-1:0]   running_id;
    logic              running_valid;
    logic              switched;
    logic              reschedule_request;
    logic              bad_request;
    int                fail_count;
    int                pending;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    priority_ready_queue_scheduler_top dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_operation          (operation),
        .i_thread_id          (thread_id),
        .i_thread_priority    (thread_priority),
        .i_current_runnable   (current_runnable),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_running_id         (running_id),
        .o_running_valid      (running_valid),
        .o_switched           (switched),
        .o_reschedule_request (reschedule_request),
        .o_bad_request        (bad_request)
    );

    prqs_checker u_chk (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_operation          (operation),
        .i_thread_id          (thread_id),
        .i_thread_priority    (thread_priority),
        .i_current_runnable   (current_runnable),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_running_id         (running_id),
        .i_running_valid      (running_valid),
        .i_switched           (switched),
        .i_reschedule_request (reschedule_request),
        .i_bad_request        (bad_request),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Called just after a rising edge; returns just after the edge that takes the item.
    task automatic issue_request(sched_op_e op, logic [ID_W-1:0] id,
                                 logic [PRIO_W-1:0] prio, logic run);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        thread_id <= id;
        thread_priority <= prio;
        current_runnable <= run;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic random_request();
        int pick;
        sched_op_e op;
        logic [PRIO_W-1:0] prio;
        pick = $urandom_range(99);
        op = (pick < 45) ? OP_ADD : (pick < 65) ? OP_REMOVE : (pick < 95) ? OP_NEXT : OP_SPARE;
        // crowd a few low levels so queues grow deep enough to unlink from the middle
        prio = ($urandom_range(3) == 0) ? PRIO_W'($urandom_range(31))
                                        : PRIO_W'($urandom_range(3));
        issue_request(op, ID_W'($urandom_range(31)), prio, $urandom_range(9) < 7);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_request(OP_NEXT, 5'd0, 5'd0, 1'b1);
        issue_request(OP_REMOVE, 5'd0, 5'd0, 1'b0);
        issue_request(OP_ADD, 5'd0, 5'd0, 1'b0);
        issue_request(OP_ADD, 5'd0, 5'd31, 1'b1);
        issue_request(OP_ADD, 5'd31, 5'd31, 1'b0);
        issue_request(OP_ADD, 5'd31, 5'd0, 1'b1);
        issue_request(OP_ADD, 5'd5, 5'd31, 1'b0);
        issue_request(OP_ADD, 5'd7, 5'd0, 1'b0);
        issue_request(OP_ADD, 5'd9, 5'd0, 1'b0);
        issue_request(OP_NEXT, 5'd31, 5'd31, 1'b1);
        issue_request(OP_NEXT, 5'd0, 5'd0, 1'b1);
        issue_request(OP_REMOVE, 5'd9, 5'd0, 1'b0);
        issue_request(OP_REMOVE, 5'd0, 5'd0, 1'b0);
        issue_request(OP_REMOVE, 5'd5, 5'd0, 1'b0);
        issue_request(OP_REMOVE, 5'd5, 5'd0, 1'b0);
        issue_request(OP_NEXT, 5'd0, 5'd0, 1'b1);
        issue_request(OP_NEXT, 5'd0, 5'd0, 1'b1);
        issue_request(OP_SPARE, 5'd31, 5'd31, 1'b1);
        issue_request(OP_NEXT, 5'd0, 5'd0, 1'b0);
        issue_request(OP_NEXT, 5'd0, 5'd0, 1'b0);
        issue_request(OP_NEXT, 5'd0, 5'd0, 1'b1);
        issue_request(OP_ADD, 5'd21, 5'd10, 1'b1);
        issue_request(OP_ADD, 5'd10, 5'd21, 1'b0);
        issue_request(OP_NEXT, 5'd0, 5'd0, 1'b0);

        for (int seg = 0; seg < 12; seg++) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            repeat (96) random_request();
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("priority_ready_queue_scheduler_top regression: pass");
        end else begin
            $display("priority_ready_queue_scheduler_top regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("priority_ready_queue_scheduler_top regression: fail");
        $finish;
    end

endmodule

### sim.f
rtl/core/prqs_pkg.sv
rtl/core/prqs_best_level.sv
rtl/core/prqs_queue_store.sv
rtl/core/priority_ready_queue_scheduler_top.sv
dv/prqs_checker.sv
dv/testbench.sv
